// ----- hw/rtl/mf3_pkg.sv -----
// Shared types and constants for the 3x3 median filter.
`default_nettype none

package mf3_pkg;

	// Width of the configuration data word.
	localparam int CFG_W = 11;

	// Number of samples in one window and the rank of the median.
	localparam int WIN_N    = 9;
	localparam int MED_RANK = 4;

	// Reset value of both image dimensions.
	localparam int DIM_RESET = 256;

	typedef logic [7:0] pix_t;

	// One entry of the row store: the two previous rows at one column.
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} row_pair_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	// Input kind carried on tuser.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/mf3_row_store.sv -----
// Row store: one memory holding the two previous image rows per column.
`default_nettype none

module mf3_row_store
	import mf3_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire row_pair_t       wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output row_pair_t            rd_data
);

	row_pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mf3_median9.sv -----
// Median of nine pixels through a fixed compare-exchange network.
`default_nettype none

module mf3_median9
	import mf3_pkg::*;
(
	input  wire pix_t [WIN_N-1:0] win,
	output pix_t                  med
);

	// Return {max, min} of two samples.
	function automatic logic [15:0] cx(input pix_t a, input pix_t b);
		return (a > b) ? {a, b} : {b, a};
	endfunction

	always_comb begin
		pix_t p [WIN_N];
		for (int i = 0; i < WIN_N; i++) begin
			p[i] = win[i];
		end
		{p[2], p[1]} = cx(p[1], p[2]);
		{p[5], p[4]} = cx(p[4], p[5]);
		{p[8], p[7]} = cx(p[7], p[8]);
		{p[1], p[0]} = cx(p[0], p[1]);
		{p[4], p[3]} = cx(p[3], p[4]);
		{p[7], p[6]} = cx(p[6], p[7]);
		{p[2], p[1]} = cx(p[1], p[2]);
		{p[5], p[4]} = cx(p[4], p[5]);
		{p[8], p[7]} = cx(p[7], p[8]);
		{p[3], p[0]} = cx(p[0], p[3]);
		{p[8], p[5]} = cx(p[5], p[8]);
		{p[7], p[4]} = cx(p[4], p[7]);
		{p[6], p[3]} = cx(p[3], p[6]);
		{p[4], p[1]} = cx(p[1], p[4]);
		{p[5], p[2]} = cx(p[2], p[5]);
		{p[7], p[4]} = cx(p[4], p[7]);
		{p[2], p[4]} = cx(p[4], p[2]);
		{p[4], p[6]} = cx(p[6], p[4]);
		{p[2], p[4]} = cx(p[4], p[2]);
		med = p[MED_RANK];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/median_filter_3x3.sv -----
// Top level of the streaming 3x3 median filter.
`default_nettype none

// Streaming 3x3 median filter for 8-bit greyscale pixels in raster order.
// Pixels outside the image count as zero. Position comes only from the
// internal row and column counters; tuser only picks between the pixel
// (image pixel) and zero (flush item). After the pixel at row r, column c
// the block emits the median centred at (r-1, c-1) when r and c are both
// at least 1, and at the end of a row also the median centred at
// (r-1, last column). After the image, send one flush request per column
// to drain the final row; its last result carries tlast (frame end).
// tuser on the output marks the last result caused by one input request.
// Rate: one input request per clock. The output side moves one result per
// clock. A row end produces two results: the first goes to the output
// register and the second parks in a hold register, so stage 2 is free for
// the next request at once. The request after a row end starts a new row
// and produces nothing, so the hold register drains without holding the
// input; the input waits only while the output is back-pressured or the
// clearing pass runs. The pipeline has three register stages: input
// register with row-store read, window assembly, then the median network
// into the output register. After reset a clearing pass zeroes the row
// store, during which no input request is taken; configuration writes are
// taken at any time.
// Configuration: index 0 image_width, index 1 image_height (1..1024,
// values of 0 act as 1, values above the maximum act as the maximum).

module median_filter_3x3
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Input pixel stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] pixel
	input  wire logic        s_axis_tuser,  // [0] command (1 = flush)

	// Filtered pixel stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] filtered_pixel
	output logic             m_axis_tlast,  // frame_end
	output logic             m_axis_tuser,  // [0] run_last

	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW0 = ($clog2(MAX_WIDTH + 1) > RW) ? $clog2(MAX_WIDTH + 1) : RW;
	localparam int XW  = (XW0 > CFG_W) ? XW0 : CFG_W;
	localparam int W_RST = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
	localparam int H_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

	// Clamp a written dimension into 1..maxv.
	function automatic logic [XW-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [XW-1:0] maxv);
		logic [XW-1:0] vx;
		vx = XW'(v);
		if (vx == '0) begin
			return XW'(1);
		end else if (vx > maxv) begin
			return maxv;
		end
		return vx;
	endfunction

	// ---------------- configuration ----------------
	logic [XW-1:0] width_q;
	logic [XW-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= XW'(W_RST);
			height_q <= XW'(H_RST);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data, XW'(MAX_WIDTH));
				CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data, XW'(MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	// ---------------- clearing pass ----------------
	logic          clr_q;
	logic [CW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == CW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + CW'(1);
		end
	end

	// ---------------- pipeline control ----------------
	logic       s1_valid_q;
	logic [1:0] pend_s2;
	logic       b_hold_q;
	logic       out_load;
	logic       s2_free;
	logic       s1_adv;
	logic       in_acc;

	// The hold register goes out first; otherwise stage 2 feeds the output.
	// Stage 2 empties whenever it hands a result over: a lone result leaves
	// completely, and of a pair the second one moves to the hold register.
	assign out_load = (b_hold_q || (pend_s2 != 2'b00)) && (!m_axis_tvalid || m_axis_tready);
	assign s2_free  = (pend_s2 == 2'b00) || (out_load && !b_hold_q);
	assign s1_adv   = s1_valid_q && s2_free;
	assign s_axis_tready = !clr_q && (!s1_valid_q || s2_free);
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	// ---------------- stage 0: counters ----------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          row_end;
	logic          flush_row;

	assign row_end   = (XW'(col_q) + XW'(1)) >= width_q;
	assign flush_row = XW'(row_q) >= height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= flush_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- stage 1 registers ----------------
	logic [CW-1:0] col_s1;
	pix_t          cur_s1;
	logic          rge1_s1, rge2_s1, cge1_s1;
	logic          row_end_s1, flush_s1;
	logic          fwd_s1;
	row_pair_t     fwd_data_s1;
	row_pair_t     rd_data;
	row_pair_t     wr_pair;
	pix_t          up_val, mid_val;
	pix_t [2:0]    newcol;

	// Row-store write by stage 1 lands at the same edge as the next read;
	// forward it when the next request reads the same column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1      <= col_q;
			cur_s1      <= (s_axis_tuser == CMD_FLUSH) ? 8'd0 : s_axis_tdata;
			rge1_s1     <= row_q >= RW'(1);
			rge2_s1     <= row_q >= RW'(2);
			cge1_s1     <= col_q != '0;
			row_end_s1  <= row_end;
			flush_s1    <= flush_row;
			fwd_s1      <= s1_adv && (col_s1 == col_q);
			fwd_data_s1 <= wr_pair;
		end
	end

	assign up_val    = fwd_s1 ? fwd_data_s1.upper  : rd_data.upper;
	assign mid_val   = fwd_s1 ? fwd_data_s1.middle : rd_data.middle;
	assign newcol[0] = rge2_s1 ? up_val  : 8'd0;
	assign newcol[1] = rge1_s1 ? mid_val : 8'd0;
	assign newcol[2] = cur_s1;

	// Shift the row history: middle becomes upper, the new pixel middle.
	assign wr_pair.upper  = newcol[1];
	assign wr_pair.middle = cur_s1;

	mf3_row_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_row_store (
		.clk     (clk),
		.wr_en   (clr_q || s1_adv),
		.wr_addr (clr_q ? clr_cnt_q : col_s1),
		.wr_data (clr_q ? row_pair_t'('0) : wr_pair),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	// Window columns c-2 (entries 0..2) and c-1 (entries 3..5).
	pix_t [5:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			if (row_end_s1) begin
				win_q <= '0;
			end else begin
				win_q <= {newcol, win_q[5:3]};
			end
		end
	end

	// ---------------- stage 2: windows ----------------
	pix_t [WIN_N-1:0] win_a_s2;   // centre at column c-1
	pix_t [WIN_N-1:0] win_b_s2;   // centre at the last column
	logic             fend_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 2'b00;
		end else if (s1_adv) begin
			pend_s2 <= {rge1_s1 && row_end_s1, rge1_s1 && cge1_s1};
		end else if (out_load && !b_hold_q) begin
			// Drop what was handed on: to the output, and of a pair also to hold.
			pend_s2 <= 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_a_s2 <= {newcol, win_q};
			win_b_s2 <= {24'd0, newcol, win_q[5:3]};
			fend_s2  <= flush_s1;
		end
	end

	// ---------------- hold register for the second result of a pair ----------------
	pix_t [WIN_N-1:0] b_win_q;
	logic             b_fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_hold_q <= 1'b0;
		end else if (out_load) begin
			b_hold_q <= !b_hold_q && (pend_s2 == 2'b11);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && !b_hold_q) begin
			b_win_q  <= win_b_s2;
			b_fend_q <= fend_s2;
		end
	end

	// ---------------- stage 3: median and output ----------------
	logic             sel_b;
	pix_t [WIN_N-1:0] med_win;
	pix_t             med;

	assign sel_b   = !pend_s2[0];
	assign med_win = b_hold_q ? b_win_q : (sel_b ? win_b_s2 : win_a_s2);

	mf3_median9 u_median (
		.win (med_win),
		.med (med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= med;
			m_axis_tlast <= b_hold_q ? b_fend_q : (sel_b && fend_s2);
			m_axis_tuser <= b_hold_q || sel_b || !pend_s2[1];
		end
	end

endmodule

`default_nettype wire

// ----- tb/median_filter_3x3_checker.sv -----
// Scoreboard for the 3x3 median filter: predicts every result and checks the output stream.
module median_filter_3x3_checker
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	input  wire logic [7:0]       s_axis_tdata,
	input  wire logic             s_axis_tuser,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [7:0]       m_axis_tdata,
	input  wire logic             m_axis_tlast,
	input  wire logic             m_axis_tuser,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		pix_t median;
		logic frame_end;
		logic run_last;
	} filt_result_t;

	filt_result_t median_q[$];
	filt_result_t want, got;

	logic [CFG_W-1:0] width_reg, height_reg;
	pix_t upper_row [MAX_WIDTH];
	pix_t middle_row [MAX_WIDTH];
	pix_t win [6];  // older column in 0..2, newer column in 3..5
	int unsigned col_pos, row_pos;
	int unsigned result_idx;

	function automatic int unsigned dim_used(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// The median is the value with at most four samples below it and at least five not above.
	function automatic pix_t median_of_nine(input logic [8:0][7:0] v);
		int below, not_above;
		pix_t m;
		m = 8'd0;
		for (int i = 0; i < 9; i++) begin
			below = 0;
			not_above = 0;
			for (int j = 0; j < 9; j++) begin
				if (v[j] < v[i])
					below++;
				if (v[j] <= v[i])
					not_above++;
			end
			if (below <= 4 && not_above >= 5)
				m = v[i];
		end
		return m;
	endfunction

	task automatic predict_request(input logic cmd, input pix_t px);
		int unsigned w, h, c, r;
		pix_t cur, up, mid;
		logic row_end, flush_row;
		filt_result_t res;
		w = dim_used(width_reg, MAX_WIDTH);
		h = dim_used(height_reg, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		cur = (cmd == CMD_FLUSH) ? 8'd0 : px;
		row_end = (c >= w - 1);
		flush_row = (r >= h);
		if (c >= MAX_WIDTH)
			c = MAX_WIDTH - 1;
		// rows above the image read as zero
		up = (r >= 2) ? upper_row[c] : 8'd0;
		mid = (r >= 1) ? middle_row[c] : 8'd0;

		if (r >= 1 && c >= 1) begin
			res.median = median_of_nine({win[0], win[1], win[2], win[3], win[4], win[5],
				up, mid, cur});
			res.frame_end = 1'b0;
			res.run_last = !row_end;
			median_q.push_back(res);
		end
		if (r >= 1 && row_end) begin
			res.median = median_of_nine({win[3], win[4], win[5], up, mid, cur,
				8'd0, 8'd0, 8'd0});
			res.frame_end = flush_row;
			res.run_last = 1'b1;
			median_q.push_back(res);
		end

		upper_row[c] = mid;
		middle_row[c] = cur;
		if (row_end) begin
			for (int k = 0; k < 6; k++)
				win[k] = 8'd0;
			col_pos = 0;
			row_pos = flush_row ? 0 : r + 1;
		end else begin
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = up;
			win[4] = mid;
			win[5] = cur;
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_W'(DIM_RESET);
			height_reg = CFG_W'(DIM_RESET);
			for (int k = 0; k < MAX_WIDTH; k++) begin
				upper_row[k] = 8'd0;
				middle_row[k] = 8'd0;
			end
			for (int k = 0; k < 6; k++)
				win[k] = 8'd0;
			col_pos = 0;
			row_pos = 0;
			result_idx = 0;
			median_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
				if (median_q.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d: none expected, got median %0d %s %0b %s %0b",
							result_idx, got.median, "frame_end", got.frame_end,
							"run_last", got.run_last);
					mismatches++;
				end else begin
					want = median_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("result %0d: expected median %0d frame_end %0b run_last %0b",
								result_idx, want.median, want.frame_end, want.run_last);
							$display("result %0d: got      median %0d frame_end %0b run_last %0b",
								result_idx, got.median, got.frame_end, got.run_last);
						end
						mismatches++;
					end
				end
				result_idx++;
			end
			// a request taken at this edge still sees the old register values
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tuser, s_axis_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_IMAGE_WIDTH:  width_reg = cfg_data;
					CFG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			pending = median_q.size();
		end
	end

endmodule

// ----- tb/median_filter_3x3_tb.sv -----
// Top of the median filter testbench: stimulus, output back-pressure, watchdog and verdict.
module median_filter_3x3_tb;
	import mf3_pkg::*;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	// Rough count of random requests after the directed and extreme frames.
	localparam int RANDOM_ITEMS = 780;
	// Idle cycles allowed before giving up. The limit covers the clearing pass
	// after reset and the longest random gap or stall.
	localparam int STUCK_LIMIT  = 6000;
	// Cycles to let the three-stage pipeline empty before a register write,
	// and after the last result at the end of the run.
	localparam int SETTLE       = 10;
	localparam int TAIL         = 16;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = 8'd0;  // [7:0] pixel
	logic             s_axis_tuser = 1'b0;  // [0] command (1 = flush)
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;         // [7:0] filtered_pixel
	logic             m_axis_tlast;         // frame_end
	logic             m_axis_tuser;         // [0] run_last
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [0:0]       cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;

	// Stimulus bookkeeping: where the next request lands in the frame, as the
	// block counts it, so that frames can be completed after a broken sequence.
	int pos_col = 0;
	int pos_row = 0;
	int eff_w = DIM_RESET;
	int eff_h = DIM_RESET;
	int sent_items = 0;
	int rand_start;
	int kind;
	int out_hold = 0;
	int out_stall;
	int stuck_cycles = 0;
	// When set, neither side idles: back-to-back traffic for a whole phase.
	bit calm = 1'b0;

	median_filter_3x3 #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	median_filter_3x3_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Gap length for either side: mostly none, often a few cycles, rarely long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Register value as the block applies it: zero acts as one, large values saturate.
	function automatic int dim_used(input int v, input int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Throttle the result side. Change tready only at the falling edge.
	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_hold--;
		end else begin
			out_stall = idle_len();
			if (out_stall == 0) begin
				m_axis_tready <= 1'b1;
				out_hold = $urandom_range(0, 6);
			end else begin
				m_axis_tready <= 1'b0;
				out_hold = out_stall - 1;
			end
		end
	end

	// Abort if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Present one request and hold it until taken. Entered and left at a falling edge.
	task automatic send_item(input logic cmd, input pix_t px);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent_items++;
		// advance the position the same way the block's counters do
		if (pos_col >= eff_w - 1) begin
			pos_col = 0;
			pos_row = (pos_row >= eff_h) ? 0 : pos_row + 1;
		end else begin
			pos_col++;
		end
	endtask

	// Pick a request that fits the current position: pixels inside the image,
	// flush requests in the padding row, with some of each swapped as noise.
	task automatic send_next(input int noise);
		int roll;
		logic cmd;
		pix_t px;
		roll = $urandom_range(0, 9);
		px = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
		if (pos_row >= eff_h)
			cmd = ($urandom_range(0, 99) < noise) ? CMD_PIXEL : CMD_FLUSH;
		else
			cmd = ($urandom_range(0, 99) < noise) ? CMD_FLUSH : CMD_PIXEL;
		send_item(cmd, px);
	endtask

	// Send until the frame in progress, padding row included, is complete.
	task automatic run_frame(input int noise);
		do send_next(noise); while (pos_col != 0 || pos_row != 0);
	endtask

	// Stop sending, wait for every outstanding result, then let the pipeline
	// settle: a request that produces nothing may still be in flight.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Hold cfg_valid across back-to-back writes; the caller drops it.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_dims(input int w, input int h);
		quiesce();
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
		cfg_valid <= 1'b0;
		eff_w = dim_used(w, MAX_WIDTH);
		eff_h = dim_used(h, MAX_HEIGHT);
	endtask

	// Mostly small images; now and then a wider or taller one, or a zero register.
	function automatic int pick_dim(input int top, input int wide_top);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 0;
		if (roll < 15)
			return $urandom_range(top + 1, wide_top);
		return $urandom_range(1, top);
	endfunction

	initial begin
		// Hold reset, then release it at a falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed 3x3 frame: full-scale pixels, a flush request inside the
		// image (reads as zero), and an image pixel in the padding row (used
		// as that row's value).
		calm = 1'b1;
		set_dims(3, 3);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h01);
		send_item(CMD_FLUSH, 8'hAA);
		send_item(CMD_PIXEL, 8'h80);
		send_item(CMD_PIXEL, 8'h7F);
		send_item(CMD_PIXEL, 8'hC8);
		send_item(CMD_FLUSH, 8'h55);
		send_item(CMD_FLUSH, 8'hFF);
		// Single-pixel images: one pixel plus one flush request each. Zero
		// registers act as one.
		set_dims(1, 1);
		send_item(CMD_PIXEL, 8'h4D);
		send_item(CMD_FLUSH, 8'h00);
		set_dims(0, 0);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_FLUSH, 8'hFF);

		// Extreme width: an oversized register saturates at the maximum. Send
		// one full row, then shrink to one column so that the padding row ends
		// with a single flush request.
		calm = 1'b0;
		set_dims(2047, 0);
		repeat (MAX_WIDTH) send_next(5);
		set_dims(1, 1);
		run_frame(5);

		// Random phases: fresh sizes, back-to-back frames without a register
		// write, and broken frames whose size changes partway through.
		rand_start = sent_items;
		while (sent_items - rand_start < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			calm = ($urandom_range(0, 4) == 0);
			if (kind < 65) begin
				set_dims(pick_dim(12, 24), pick_dim(8, 12));
				run_frame($urandom_range(0, 8));
			end else if (kind < 80) begin
				run_frame($urandom_range(0, 8));
			end else begin
				// Drain partway, then shrink or grow: counters may now be past
				// the last column or in the padding row already.
				set_dims($urandom_range(4, 16), $urandom_range(3, 8));
				repeat ($urandom_range(1, eff_w * eff_h)) send_next($urandom_range(0, 8));
				set_dims($urandom_range(1, 16), $urandom_range(1, 8));
				run_frame($urandom_range(0, 8));
			end
		end

		// Drop valid, wait for the last results, then give stray results time to show.
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_row_store.sv
hw/rtl/mf3_median9.sv
hw/rtl/median_filter_3x3.sv
tb/median_filter_3x3_checker.sv
tb/median_filter_3x3_tb.sv
